@@ design/sic_pkg.sv @@
// ---------------------------------------------------------------------------
// sic_pkg: shared types and constants for stepper index calibration
// Request/response payloads, phase encoding and the half-step coil table.
// ---------------------------------------------------------------------------
package sic_pkg;

   localparam int COUNT_BITS_DEFAULT = 16;
   localparam int OFFSET_BITS        = 10;
   localparam int INDEX_BITS         = 3;
   localparam int COIL_BITS          = 4;
   localparam int REV_BITS           = 16;

   localparam logic [OFFSET_BITS-1:0] OFFSET_STEPS_RESET = OFFSET_BITS'(140);

   localparam logic MODE_TICK  = 1'b0;
   localparam logic MODE_START = 1'b1;

   typedef enum logic [3:0] {
      PHASE_IDLE    = 4'b0001,
      PHASE_FIND    = 4'b0010,
      PHASE_MEASURE = 4'b0100,
      PHASE_OFFSET  = 4'b1000
   } phase_type;

   typedef struct packed {
      logic mode;
      logic opto_level;
   } req_type;

   typedef struct packed {
      logic [COIL_BITS-1:0] coil_pattern;
      logic                 stepped;
      logic                 busy_res;
      logic                 done_res;
      logic [REV_BITS-1:0]  revolution_steps;
   } rsp_type;

   // Control state, except the revolution counter whose width is a parameter
   typedef struct packed {
      phase_type              phase;
      logic                   prev_level;
      logic [INDEX_BITS-1:0]  half_step_index;
      logic [OFFSET_BITS-1:0] offset_count;
   } calib_state_type;

   localparam calib_state_type CALIB_STATE_RESET = '{
      phase:           PHASE_IDLE,
      prev_level:      1'b0,
      half_step_index: '0,
      offset_count:    '0
   };

   // Half-step drive sequence, bit0 = coil one
   function automatic logic [COIL_BITS-1:0] coil_lookup(input logic [INDEX_BITS-1:0] idx);
      logic [COIL_BITS-1:0] pat;
      case (idx)
         3'd0:    pat = 4'h1;
         3'd1:    pat = 4'h3;
         3'd2:    pat = 4'h2;
         3'd3:    pat = 4'h6;
         3'd4:    pat = 4'h4;
         3'd5:    pat = 4'hC;
         3'd6:    pat = 4'h8;
         3'd7:    pat = 4'h9;
         default: pat = 4'h1;
      endcase
      return pat;
   endfunction

endpackage

@@ design/sic_step.sv @@
// ---------------------------------------------------------------------------
// sic_step: calibration next-state logic
// Computes the new state and the response for one request.
// ---------------------------------------------------------------------------
module sic_step
   import sic_pkg::*;
#(
   parameter int COUNT_BITS = COUNT_BITS_DEFAULT
) (
   input  req_type                 req,
   input  calib_state_type         state_cur,
   input  logic [COUNT_BITS-1:0]   step_count_cur,
   input  logic [OFFSET_BITS-1:0]  offset_steps,
   output calib_state_type         state_nxt,
   output logic [COUNT_BITS-1:0]   step_count_nxt,
   output rsp_type                 rsp
);

   localparam int EXT_BITS = (COUNT_BITS > REV_BITS) ? COUNT_BITS : REV_BITS;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
   localparam logic [EXT_BITS-1:0]   REV_MAX   = EXT_BITS'({REV_BITS{1'b1}});

   logic                   falling;
   logic                   done;
   logic                   stepped;
   logic [OFFSET_BITS-1:0] offset_inc;
   logic [COUNT_BITS-1:0]  count_sat_inc;
   logic [INDEX_BITS-1:0]  index_inc;
   logic [EXT_BITS-1:0]    count_ext;

   assign falling       = state_cur.prev_level && !req.opto_level;
   assign offset_inc    = state_cur.offset_count + OFFSET_BITS'(1);
   assign index_inc     = state_cur.half_step_index + INDEX_BITS'(1);
   assign count_sat_inc = (step_count_cur == COUNT_MAX) ? step_count_cur
                                                        : step_count_cur + COUNT_BITS'(1);
   assign count_ext     = EXT_BITS'(step_count_nxt);

   always_comb begin
      state_nxt      = state_cur;
      step_count_nxt = step_count_cur;
      stepped        = 1'b0;
      done           = 1'b0;

      if (req.mode == MODE_START) begin
         state_nxt.phase           = PHASE_FIND;
         state_nxt.prev_level      = req.opto_level;
         state_nxt.offset_count    = '0;
         state_nxt.half_step_index = index_inc;
         step_count_nxt            = COUNT_BITS'(1);
         stepped                   = 1'b1;
      end else begin
         case (state_cur.phase)
            PHASE_FIND, PHASE_MEASURE: begin
               if (!falling) begin
                  state_nxt.prev_level      = req.opto_level;
                  state_nxt.half_step_index = index_inc;
                  step_count_nxt            = count_sat_inc;
                  stepped                   = 1'b1;
               end else if (state_cur.phase == PHASE_FIND) begin
                  // index found: restart the count for one revolution
                  state_nxt.phase           = PHASE_MEASURE;
                  state_nxt.prev_level      = req.opto_level;
                  state_nxt.half_step_index = index_inc;
                  step_count_nxt            = COUNT_BITS'(1);
                  stepped                   = 1'b1;
               end else if (offset_steps == '0) begin
                  state_nxt.phase        = PHASE_IDLE;
                  state_nxt.offset_count = '0;
                  done                   = 1'b1;
               end else begin
                  state_nxt.half_step_index = index_inc;
                  state_nxt.offset_count    = OFFSET_BITS'(1);
                  stepped                   = 1'b1;
                  if (offset_steps == OFFSET_BITS'(1)) begin
                     state_nxt.phase = PHASE_IDLE;
                     done            = 1'b1;
                  end else begin
                     state_nxt.phase = PHASE_OFFSET;
                  end
               end
            end
            PHASE_OFFSET: begin
               state_nxt.half_step_index = index_inc;
               state_nxt.offset_count    = offset_inc;
               stepped                   = 1'b1;
               if (offset_inc >= offset_steps || offset_inc == '0) begin
                  state_nxt.phase = PHASE_IDLE;
                  done            = 1'b1;
               end
            end
            default: begin
               // idle tick: hold everything
            end
         endcase
      end
   end

   always_comb begin
      rsp.coil_pattern     = coil_lookup(state_nxt.half_step_index);
      rsp.stepped          = stepped;
      rsp.busy_res         = (state_nxt.phase != PHASE_IDLE);
      rsp.done_res         = done;
      rsp.revolution_steps = '0;
      if (done) begin
         rsp.revolution_steps = (count_ext > REV_MAX) ? {REV_BITS{1'b1}}
                                                      : count_ext[REV_BITS-1:0];
      end
   end

endmodule

@@ design/stepper_index_calibration.sv @@
// ---------------------------------------------------------------------------
// stepper_index_calibration: half-step stepper calibration on an index sensor
// Input register, one-pass state update, and a response register.
// ---------------------------------------------------------------------------
// Usage:
//   Send a start request (mode = 1) with the current sensor level; the block
//   issues the first half-step. Then send one tick request (mode = 0) per
//   sensor reading taken after the previous step. Each request returns
//   exactly one response with the coil drive, a stepped flag and busy/done.
//   The first search round finds the index (a high-to-low sensor edge), the
//   second counts one revolution, then offset_steps extra half-steps follow;
//   the last (at zero offset, the closing edge) reports done and revolution count.
//   Channels: req_* and rsp_* use valid/ready; csr_write_enable loads the
//   offset register in the same edge, with no wait. Write it only when idle.
//   Path: the accepting edge loads the input register; the response
//   register is loaded once it is free, and rsp_valid rises with it.
//   Throughput: one request per cycle while rsp_ready stays high, set by
//   the combinational state update between the two registers.
//   Stall: while rsp_ready is low the response holds and one more request
//   may wait in the input register; req_ready then drops.
//   Reset: both stages empty, phase idle, coil index zero (drive 0x1), counts
//   zero, offset register back to 140.
// ---------------------------------------------------------------------------
module stepper_index_calibration
   import sic_pkg::*;
#(
   parameter int COUNT_BITS = COUNT_BITS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  req_type                req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output rsp_type                rsp_data,
   input  logic                   csr_write_enable,
   input  logic [OFFSET_BITS-1:0] csr_write_data
);

   // Input stage
   logic    in_valid_ff, in_valid_in;
   req_type in_req_ff,   in_req_in;

   // Response stage
   logic    out_valid_ff, out_valid_in;
   rsp_type out_rsp_ff,   out_rsp_in;

   // Calibration state
   calib_state_type        state_ff,      state_in;
   logic [COUNT_BITS-1:0]  step_count_ff, step_count_in;
   logic [OFFSET_BITS-1:0] offset_steps_ff, offset_steps_in;

   calib_state_type        state_calc;
   logic [COUNT_BITS-1:0]  step_count_calc;
   rsp_type                rsp_calc;
   logic                   advance;

   // Move the held request into the response stage when that stage is free
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_rsp_ff;

   sic_step #(
      .COUNT_BITS(COUNT_BITS)
   ) u_step (
      .req            (in_req_ff),
      .state_cur      (state_ff),
      .step_count_cur (step_count_ff),
      .offset_steps   (offset_steps_ff),
      .state_nxt      (state_calc),
      .step_count_nxt (step_count_calc),
      .rsp            (rsp_calc)
   );

   always_comb begin
      in_valid_in     = in_valid_ff;
      in_req_in       = in_req_ff;
      out_valid_in    = out_valid_ff;
      out_rsp_in      = out_rsp_ff;
      state_in        = state_ff;
      step_count_in   = step_count_ff;
      offset_steps_in = offset_steps_ff;

      // drop the response once taken
      if (out_valid_ff && rsp_ready) begin
         out_valid_in = 1'b0;
      end
      if (advance) begin
         out_valid_in  = 1'b1;
         out_rsp_in    = rsp_calc;
         state_in      = state_calc;
         step_count_in = step_count_calc;
         in_valid_in   = 1'b0;
      end
      // capture a new request
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
         in_req_in   = req_data;
      end
      if (csr_write_enable) begin
         offset_steps_in = csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff     <= 1'b0;
         out_valid_ff    <= 1'b0;
         state_ff        <= CALIB_STATE_RESET;
         step_count_ff   <= '0;
         offset_steps_ff <= OFFSET_STEPS_RESET;
      end else begin
         in_valid_ff     <= in_valid_in;
         out_valid_ff    <= out_valid_in;
         state_ff        <= state_in;
         step_count_ff   <= step_count_in;
         offset_steps_ff <= offset_steps_in;
      end
   end

   always_ff @(posedge clock) begin
      in_req_ff  <= in_req_in;
      out_rsp_ff <= out_rsp_in;
   end

`ifndef NO_ASSERTIONS
   a_done_not_busy: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_rsp_ff.done_res |-> !out_rsp_ff.busy_res)
      else $error("done reported while still busy");

   a_rev_only_on_done: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !out_rsp_ff.done_res |-> out_rsp_ff.revolution_steps == '0)
      else $error("revolution count shown without done");

   a_step_advances_index: assert property (@(posedge clock) disable iff (reset)
      advance && rsp_calc.stepped |=>
         state_ff.half_step_index == $past(state_ff.half_step_index) + INDEX_BITS'(1))
      else $error("half-step index did not advance on a step");

   a_advance_fills_output: assert property (@(posedge clock) disable iff (reset)
      advance |=> out_valid_ff)
      else $error("advanced request produced no response");

   a_idle_state_stable: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(state_ff) && $stable(step_count_ff))
      else $error("calibration state changed without a request");
`endif

endmodule

@@ verif/tb_stepper_index_calibration.sv @@
// ---------------------------------------------------------------------------
// tb_stepper_index_calibration: self-checking bench for index calibration
// A queue-fed driver sends start and tick requests and offset register
// writes. A clocked monitor predicts the coil drive, step, busy, done and
// revolution count of every accepted request and checks each response in
// order. Both channels idle at random in the first two of three rounds of pressure.
// ---------------------------------------------------------------------------
module tb_stepper_index_calibration;
   import sic_pkg::*;

   // Run limits and widths
   localparam int CYCLE_LIMIT    = 60000;
   localparam int RANDOM_ITEMS   = 850;
   localparam int REV_COUNT_BITS = COUNT_BITS_DEFAULT;

   // Half-step coil drive, entry 0 in the low nibble
   localparam logic [8*COIL_BITS-1:0] COIL_SEQUENCE =
      {4'h9, 4'h8, 4'hC, 4'h4, 4'h6, 4'h2, 4'h3, 4'h1};

   typedef enum logic [1:0] {
      ENTRY_REQUEST,
      ENTRY_CSR_WRITE,
      ENTRY_DRAIN,
      ENTRY_IDLE_MIX
   } entry_kind_type;

   typedef struct packed {
      entry_kind_type         kind;
      req_type                req;
      logic [OFFSET_BITS-1:0] value;
      logic [6:0]             send_pct;
      logic [6:0]             recv_pct;
   } plan_entry_type;

   // Block ports, inputs driven to known values from time zero
   logic                   clock            = 1'b0;
   logic                   reset            = 1'b1;
   logic                   req_valid        = 1'b0;
   logic                   req_ready;
   req_type                req_data         = '0;
   logic                   rsp_valid;
   logic                   rsp_ready        = 1'b0;
   rsp_type                rsp_data;
   logic                   csr_write_enable = 1'b0;
   logic [OFFSET_BITS-1:0] csr_write_data   = '0;

   // Stimulus plan and expected coil drive responses
   plan_entry_type request_plan_q[$];
   rsp_type        expected_drive_q[$];

   int   plan_items    = 0;
   int   error_count   = 0;
   int   cycle_count   = 0;
   int   send_idle_pct = 0;
   int   recv_idle_pct = 0;
   logic req_fire      = 1'b0;

   // Calibration state as the block should hold it
   phase_type                 phase_m       = PHASE_IDLE;
   logic                      prev_level_m  = 1'b0;
   logic [INDEX_BITS-1:0]     half_step_m   = '0;
   logic [REV_COUNT_BITS-1:0] step_count_m  = '0;
   logic [OFFSET_BITS-1:0]    offset_count_m = '0;
   logic [OFFSET_BITS-1:0]    offset_reg_m  = OFFSET_STEPS_RESET;

   stepper_index_calibration uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always #1 clock = ~clock;

   // ------------------------------------------------------------------------
   // Prediction
   // ------------------------------------------------------------------------

   // Advance the half-step index and count the step, holding at full scale
   task automatic take_counted_step();
      half_step_m = half_step_m + 1'b1;
      if (step_count_m != '1) begin
         step_count_m = step_count_m + 1'b1;
      end
   endtask

   // Apply one request to the calibration state and form the response
   task automatic predict_coil_response(input req_type r, output rsp_type drive);
      logic stepped;
      logic done;
      stepped = 1'b0;
      done    = 1'b0;
      if (r.mode == MODE_START) begin
         // Start restarts from the find round, even when already busy
         phase_m        = PHASE_FIND;
         prev_level_m   = r.opto_level;
         step_count_m   = '0;
         offset_count_m = '0;
         take_counted_step();
         stepped = 1'b1;
      end else if (phase_m == PHASE_FIND || phase_m == PHASE_MEASURE) begin
         if (!(prev_level_m && !r.opto_level)) begin
            prev_level_m = r.opto_level;
            take_counted_step();
            stepped = 1'b1;
         end else if (phase_m == PHASE_FIND) begin
            // Index found: begin the measured revolution with its first step
            phase_m      = PHASE_MEASURE;
            prev_level_m = r.opto_level;
            step_count_m = '0;
            take_counted_step();
            stepped = 1'b1;
         end else begin
            // Revolution measured: enter offset stepping, or finish at once
            offset_count_m = '0;
            if (offset_reg_m == '0) begin
               phase_m = PHASE_IDLE;
               done    = 1'b1;
            end else begin
               phase_m        = PHASE_OFFSET;
               half_step_m    = half_step_m + 1'b1;
               offset_count_m = OFFSET_BITS'(1);
               stepped        = 1'b1;
               if (offset_count_m >= offset_reg_m) begin
                  phase_m = PHASE_IDLE;
                  done    = 1'b1;
               end
            end
         end
      end else if (phase_m == PHASE_OFFSET) begin
         half_step_m    = half_step_m + 1'b1;
         offset_count_m = offset_count_m + 1'b1;
         stepped        = 1'b1;
         // Compare against the current register, which may have shrunk
         if (offset_count_m >= offset_reg_m || offset_count_m == '0) begin
            phase_m = PHASE_IDLE;
            done    = 1'b1;
         end
      end
      // A tick while idle changes nothing and reports the held drive

      drive.coil_pattern     = COIL_SEQUENCE[half_step_m*COIL_BITS +: COIL_BITS];
      drive.stepped          = stepped;
      drive.busy_res         = (phase_m != PHASE_IDLE);
      drive.done_res         = done;
      drive.revolution_steps = '0;
      if (done) begin
         drive.revolution_steps = (step_count_m > {REV_BITS{1'b1}}) ?
                                  {REV_BITS{1'b1}} : REV_BITS'(step_count_m);
      end
   endtask

   task automatic compare_field(input string name, input int want, input int got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         error_count++;
      end
   endtask

   // ------------------------------------------------------------------------
   // Monitor: predict on each accepted request, check each accepted response
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : monitor
      rsp_type predicted;
      rsp_type oldest;
      cycle_count = cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d responses outstanding", $time,
                  expected_drive_q.size());
         $display("Some tests failed");
         $finish;
      end else if (!reset) begin
         req_fire <= req_valid && req_ready;
         if (csr_write_enable) begin
            offset_reg_m = csr_write_data;
         end
         if (req_valid && req_ready) begin
            predict_coil_response(req_data, predicted);
            expected_drive_q.push_back(predicted);
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_drive_q.size() == 0) begin
               $display("%0t: unexpected response, expected none, actual %0h",
                        $time, rsp_data);
               error_count++;
            end else begin
               oldest = expected_drive_q.pop_front();
               compare_field("coil_pattern", int'(oldest.coil_pattern),
                             int'(rsp_data.coil_pattern));
               compare_field("stepped", int'(oldest.stepped), int'(rsp_data.stepped));
               compare_field("busy_res", int'(oldest.busy_res), int'(rsp_data.busy_res));
               compare_field("done_res", int'(oldest.done_res), int'(rsp_data.done_res));
               compare_field("revolution_steps", int'(oldest.revolution_steps),
                             int'(rsp_data.revolution_steps));
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Driver: work through the plan at the falling edge
   // ------------------------------------------------------------------------
   always @(negedge clock) begin : driver
      plan_entry_type         head;
      logic                   next_valid;
      req_type                next_data;
      logic                   next_we;
      logic [OFFSET_BITS-1:0] next_wd;
      next_valid = req_valid;
      next_data  = req_data;
      next_we    = 1'b0;
      next_wd    = csr_write_data;
      if (!reset) begin
         // Hold a request that is still waiting for acceptance
         if (!(req_valid && !req_fire)) begin
            next_valid = 1'b0;
            if (request_plan_q.size() > 0) begin
               head = request_plan_q[0];
               case (head.kind)
                  ENTRY_REQUEST: begin
                     if ($urandom_range(0, 99) >= send_idle_pct) begin
                        next_valid = 1'b1;
                        next_data  = head.req;
                        void'(request_plan_q.pop_front());
                     end
                  end
                  ENTRY_CSR_WRITE: begin
                     // Write only once every response is back
                     if (expected_drive_q.size() == 0) begin
                        next_we = 1'b1;
                        next_wd = head.value;
                        void'(request_plan_q.pop_front());
                     end
                  end
                  ENTRY_DRAIN: begin
                     if (expected_drive_q.size() == 0) begin
                        void'(request_plan_q.pop_front());
                     end
                  end
                  default: begin
                     send_idle_pct = head.send_pct;
                     recv_idle_pct = head.recv_pct;
                     void'(request_plan_q.pop_front());
                  end
               endcase
            end
         end
         req_valid        <= next_valid;
         req_data         <= next_data;
         csr_write_enable <= next_we;
         csr_write_data   <= next_wd;
         rsp_ready        <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   // ------------------------------------------------------------------------
   // Plan building
   // ------------------------------------------------------------------------
   task automatic push_request(input logic mode, input logic level);
      plan_entry_type e;
      e                = '0;
      e.kind           = ENTRY_REQUEST;
      e.req.mode       = mode;
      e.req.opto_level = level;
      request_plan_q.push_back(e);
      plan_items++;
   endtask

   task automatic push_csr(input int value);
      plan_entry_type e;
      e       = '0;
      e.kind  = ENTRY_CSR_WRITE;
      e.value = OFFSET_BITS'(value);
      request_plan_q.push_back(e);
   endtask

   task automatic push_drain();
      plan_entry_type e;
      e      = '0;
      e.kind = ENTRY_DRAIN;
      request_plan_q.push_back(e);
   endtask

   task automatic push_idle_mix(input int send_pct, input int recv_pct);
      plan_entry_type e;
      e          = '0;
      e.kind     = ENTRY_IDLE_MIX;
      e.send_pct = 7'(send_pct);
      e.recv_pct = 7'(recv_pct);
      request_plan_q.push_back(e);
   endtask

   // One search round: lows, then highs, then the falling edge that ends it.
   // Lows are only allowed while the latched level is still low.
   task automatic push_round(input logic latched);
      int lows;
      int highs;
      lows  = latched ? 0 : $urandom_range(0, 4);
      highs = $urandom_range(latched ? 0 : 1, 5);
      repeat (lows) push_request(MODE_TICK, 1'b0);
      repeat (highs) push_request(MODE_TICK, 1'b1);
      push_request(MODE_TICK, 1'b0);
   endtask

   // Start, find round, measure round, then the given number of offset ticks
   task automatic push_calibration(input int offset_ticks);
      logic level;
      level = 1'($urandom_range(0, 1));
      push_request(MODE_START, level);
      push_round(level);
      push_round(1'b0);
      repeat (offset_ticks) push_request(MODE_TICK, 1'($urandom_range(0, 1)));
   endtask

   // ------------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------------
   initial begin : main
      int offset_setting;
      int pick;
      int stage;
      stage = 0;

      // First round of pressure: sender idles lightly, receiver heavily
      push_idle_mix(21, 57);

      // Ticks while idle do nothing
      push_request(MODE_TICK, 1'b0);
      push_request(MODE_TICK, 1'b1);

      // Zero offset: done lands on the measure edge, without a step
      push_csr(0);
      push_request(MODE_START, 1'b1);
      push_request(MODE_TICK, 1'b0);
      push_request(MODE_TICK, 1'b1);
      push_request(MODE_TICK, 1'b0);

      // Restart while busy, then a full zero-offset calibration
      push_request(MODE_START, 1'b0);
      push_request(MODE_TICK, 1'b1);
      push_request(MODE_START, 1'b1);
      push_request(MODE_TICK, 1'b0);
      push_request(MODE_TICK, 1'b0);
      push_request(MODE_TICK, 1'b1);
      push_request(MODE_TICK, 1'b1);
      push_request(MODE_TICK, 1'b0);

      // Offset of one: the measure edge itself issues the only offset step
      push_drain();
      push_csr(1);
      push_request(MODE_START, 1'b0);
      push_request(MODE_TICK, 1'b1);
      push_request(MODE_TICK, 1'b0);
      push_request(MODE_TICK, 1'b1);
      push_request(MODE_TICK, 1'b0);
      push_request(MODE_TICK, 1'b1);

      // Largest offset, shrunk below the count mid-stepping: next tick ends it
      push_drain();
      push_csr(1023);
      push_calibration(20);
      push_drain();
      push_csr(3);
      push_request(MODE_TICK, 1'b1);
      offset_setting = 3;

      // Random part: mostly well-formed calibrations, some broken and noise
      while (plan_items < RANDOM_ITEMS) begin
         if (stage == 0 && plan_items >= RANDOM_ITEMS / 3) begin
            push_idle_mix(57, 21);
            stage = 1;
         end else if (stage == 1 && plan_items >= 2 * RANDOM_ITEMS / 3) begin
            push_idle_mix(0, 0);
            stage = 2;
         end
         if ($urandom_range(0, 3) == 0) begin
            pick = $urandom_range(0, 9);
            if (pick < 3) begin
               offset_setting = 0;
            end else if (pick < 9) begin
               offset_setting = $urandom_range(1, 6);
            end else begin
               offset_setting = $urandom_range(7, 60);
            end
            push_drain();
            push_csr(offset_setting);
         end
         pick = $urandom_range(0, 9);
         if (pick < 7) begin
            push_calibration(offset_setting > 0 ? offset_setting - 1 : 0);
         end else if (pick == 7) begin
            // Broken: cut short after the find round with random ticks
            push_request(MODE_START, 1'b1);
            push_round(1'b1);
            repeat ($urandom_range(0, 6))
               push_request(MODE_TICK, 1'($urandom_range(0, 1)));
         end else if (pick == 8) begin
            repeat ($urandom_range(1, 4))
               push_request(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
         end else begin
            // Hold the sender until every response is back
            push_drain();
            push_calibration(offset_setting > 0 ? offset_setting - 1 : 0);
         end
      end

      // Reset once, released at a falling edge
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Drain the plan and every outstanding response, then let the pipe settle
      while (request_plan_q.size() != 0 || expected_drive_q.size() != 0 || req_valid)
         @(posedge clock);
      repeat (8) @(posedge clock);

      if (error_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
